// ===== src/mrf_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus RTU request framer.
`default_nettype none

package mrf_pkg;

    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;
    localparam logic [7:0]  ByteMask = 8'hFF;

    localparam logic [15:0] MaxWriteRegs = 16'd123;
    localparam int unsigned WordsWidth = 7;

    localparam logic OpHeader = 1'b0;
    localparam logic OpValue  = 1'b1;

    localparam logic [7:0] FcReadHolding   = 8'd3;
    localparam logic [7:0] FcReadInput     = 8'd4;
    localparam logic [7:0] FcWriteSingle   = 8'd6;
    localparam logic [7:0] FcWriteMultiple = 8'd16;

    localparam logic [1:0] StOk          = 2'd0;
    localparam logic [1:0] StUnsupported = 2'd1;
    localparam logic [1:0] StBadCount    = 2'd2;
    localparam logic [1:0] StStrayValue  = 2'd3;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
    localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

    typedef enum logic [1:0] {
        JOB_ERR = 2'd0,
        JOB_HDR = 2'd1,
        JOB_VAL = 2'd2
    } job_kind_t;

    typedef struct packed {
        logic        operation;
        logic [7:0]  dev_addr;
        logic [7:0]  fn_code;
        logic [15:0] first_reg;
        logic [15:0] count_or_value;
    } item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       frame_end;
        logic [1:0] status;
    } result_t;

    // One unit of work for the byte sequencer.
    typedef struct packed {
        job_kind_t   kind;
        logic        close;   // append CRC after the data bytes
        logic [1:0]  status;
        logic [7:0]  dev_addr;
        logic [7:0]  fn_code;
        logic [15:0] first_reg;
        logic [15:0] count_or_value;
    } job_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CrcPoly;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/mrf_front.sv =====
// Front end: accepts request items, tracks the pending write-multiple frame, issues jobs.
`default_nettype none

module mrf_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mrf_pkg::item_t  item,
    output logic                 full,
    output logic                 job_valid,
    output mrf_pkg::job_t        job,
    input  wire logic            job_full
);

    logic [mrf_pkg::WordsWidth-1:0] words_left_reg, words_left_next;
    logic                           frame_open_reg, frame_open_next;
    logic                           accept;
    logic                           fc_ok;
    logic                           count_bad;

    assign full   = job_full;
    assign accept = push && !job_full;

    assign fc_ok = (item.fn_code == mrf_pkg::FcReadHolding)
                || (item.fn_code == mrf_pkg::FcReadInput)
                || (item.fn_code == mrf_pkg::FcWriteSingle)
                || (item.fn_code == mrf_pkg::FcWriteMultiple);
    assign count_bad = (item.count_or_value == 16'd0)
                    || (item.count_or_value > mrf_pkg::MaxWriteRegs);

    always_comb
    begin
        words_left_next = words_left_reg;
        frame_open_next = frame_open_reg;
        job.kind           = mrf_pkg::JOB_ERR;
        job.close          = 1'b0;
        job.status         = mrf_pkg::StOk;
        job.dev_addr       = item.dev_addr;
        job.fn_code        = item.fn_code;
        job.first_reg      = item.first_reg;
        job.count_or_value = item.count_or_value;

        if (item.operation == mrf_pkg::OpValue)
        begin
            if (!frame_open_reg || words_left_reg == '0)
            begin
                job.status = mrf_pkg::StStrayValue;
            end
            else
            begin
                job.kind        = mrf_pkg::JOB_VAL;
                words_left_next = words_left_reg - 1'b1;
                if (words_left_reg == mrf_pkg::WordsWidth'(1))
                begin
                    job.close       = 1'b1;
                    frame_open_next = 1'b0;
                end
            end
        end
        else
        begin
            // a header abandons whatever frame was pending
            words_left_next = '0;
            frame_open_next = 1'b0;
            priority if (!fc_ok)
            begin
                job.status = mrf_pkg::StUnsupported;
            end
            else if (item.fn_code == mrf_pkg::FcWriteMultiple && count_bad)
            begin
                job.status = mrf_pkg::StBadCount;
            end
            else if (item.fn_code == mrf_pkg::FcWriteMultiple)
            begin
                job.kind        = mrf_pkg::JOB_HDR;
                words_left_next = item.count_or_value[mrf_pkg::WordsWidth-1:0];
                frame_open_next = 1'b1;
            end
            else
            begin
                job.kind  = mrf_pkg::JOB_HDR;
                job.close = 1'b1;
            end
        end
    end

    assign job_valid = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_left_reg <= '0;
            frame_open_reg <= 1'b0;
        end
        else if (accept)
        begin
            words_left_reg <= words_left_next;
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mrf_queue.sv =====
// Short job queue between the front end and the byte sequencer.
`default_nettype none

module mrf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire mrf_pkg::job_t  wr_data,
    output logic                full,
    input  wire logic           rd_en,
    output logic                rd_valid,
    output mrf_pkg::job_t       rd_data
);

    mrf_pkg::job_t                        mem_reg [mrf_pkg::QueueDepth];
    logic [mrf_pkg::QueuePtrWidth-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [mrf_pkg::QueueCntWidth-1:0]    count_reg, count_next;
    logic                                 do_wr, do_rd;

    assign full     = (count_reg == mrf_pkg::QueueCntWidth'(mrf_pkg::QueueDepth));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mrf_back.sv =====
// Byte sequencer: walks each job byte by byte, runs the CRC, holds the result register.
`default_nettype none

module mrf_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    input  wire mrf_pkg::job_t    job,
    output logic                  job_take,
    output logic                  empty,
    input  wire logic             pop,
    output mrf_pkg::result_t      result
);

    logic [2:0]        idx_reg;
    logic [15:0]       crc_reg;
    logic [15:0]       crc_base;
    logic [15:0]       crc_step;
    logic              out_valid_reg;
    mrf_pkg::result_t  out_reg;
    mrf_pkg::result_t  cur;
    logic              is_data;
    logic              done;
    logic              fire;

    always_comb
    begin
        cur.frame_byte = '0;
        cur.last_byte  = 1'b0;
        cur.frame_end  = 1'b0;
        cur.status     = job.status;
        is_data        = 1'b0;
        done           = 1'b0;
        unique case (job.kind)
            mrf_pkg::JOB_ERR:
            begin
                cur.last_byte = 1'b1;
                done          = 1'b1;
            end
            mrf_pkg::JOB_HDR:
            begin
                is_data = 1'b1;
                unique case (idx_reg)
                    3'd0: cur.frame_byte = job.dev_addr;
                    3'd1: cur.frame_byte = job.fn_code;
                    3'd2: cur.frame_byte = job.first_reg[15:8];
                    3'd3: cur.frame_byte = job.first_reg[7:0];
                    3'd4: cur.frame_byte = job.count_or_value[15:8];
                    3'd5: cur.frame_byte = job.count_or_value[7:0];
                    3'd6:
                    begin
                        if (job.close)
                        begin
                            cur.frame_byte = crc_reg[7:0];
                            is_data        = 1'b0;
                        end
                        else
                        begin
                            // byte count of a write-multiple frame
                            cur.frame_byte = {job.count_or_value[6:0], 1'b0};
                            cur.last_byte  = 1'b1;
                            done           = 1'b1;
                        end
                    end
                    default:
                    begin
                        cur.frame_byte = crc_reg[15:8];
                        cur.last_byte  = 1'b1;
                        cur.frame_end  = 1'b1;
                        is_data        = 1'b0;
                        done           = 1'b1;
                    end
                endcase
            end
            mrf_pkg::JOB_VAL:
            begin
                unique case (idx_reg)
                    3'd0:
                    begin
                        cur.frame_byte = job.count_or_value[15:8];
                        is_data        = 1'b1;
                    end
                    3'd1:
                    begin
                        cur.frame_byte = job.count_or_value[7:0];
                        is_data        = 1'b1;
                        cur.last_byte  = !job.close;
                        done           = !job.close;
                    end
                    3'd2:
                        cur.frame_byte = crc_reg[7:0];
                    default:
                    begin
                        cur.frame_byte = crc_reg[15:8];
                        cur.last_byte  = 1'b1;
                        cur.frame_end  = 1'b1;
                        done           = 1'b1;
                    end
                endcase
            end
            default:
            begin
                cur.last_byte = 1'b1;
                done          = 1'b1;
            end
        endcase
    end

    // a header starts a fresh CRC
    assign crc_base = (job.kind == mrf_pkg::JOB_HDR && idx_reg == '0) ? mrf_pkg::CrcInit : crc_reg;
    assign crc_step = mrf_pkg::crc_byte(crc_base, cur.frame_byte & mrf_pkg::ByteMask);

    assign fire     = job_valid && (!out_valid_reg || pop);
    assign job_take = fire && done;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= mrf_pkg::CrcInit;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= done ? 3'd0 : idx_reg + 1'b1;
                if (is_data)
                    crc_reg <= crc_step;
                else if (cur.frame_end)
                    crc_reg <= mrf_pkg::CrcInit;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/modbus_rtu_request_framer.sv =====
// Top level of the Modbus RTU request framer.
//
// Items go in through push/full and frame bytes come out through empty/pop, one result per
// byte or rejected item. The front end classifies each item in the cycle it is accepted and
// drops a job into a two-entry queue; the byte sequencer behind it emits one byte per cycle
// while its output is popped: a read or write-single header gives 8 bytes, a write-multiple
// header 7, a value item 2 (4 when it closes the frame with the CRC) and an error result 1.
// That byte rate sets the throughput; items are accepted back to back while the job queue
// has room; output backpressure stalls the sequencer and, once the queue is full, the input.
`default_nettype none

module modbus_rtu_request_framer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire mrf_pkg::item_t    item,
    output logic                   empty,
    input  wire logic              pop,
    output mrf_pkg::result_t       result
);

    logic           fq_valid;
    mrf_pkg::job_t  fq_job;
    logic           fq_full;
    logic           qb_valid;
    mrf_pkg::job_t  qb_job;
    logic           qb_take;

    mrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .job_valid (fq_valid),
        .job       (fq_job),
        .job_full  (fq_full)
    );

    mrf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fq_valid),
        .wr_data  (fq_job),
        .full     (fq_full),
        .rd_en    (qb_take),
        .rd_valid (qb_valid),
        .rd_data  (qb_job)
    );

    mrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job       (qb_job),
        .job_take  (qb_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== src/mrf_checker.sv =====
// Port-level checks for the framer, bound to the top level.
`default_nettype none

module mrf_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              empty,
    input wire logic              pop,
    input wire mrf_pkg::result_t  result
);

    // a waiting beat holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result beat changed while waiting");

    a_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_end) |-> (result.last_byte && result.status == mrf_pkg::StOk))
        else $error("frame end without last byte or with error status");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.status != mrf_pkg::StOk)
            |-> (result.frame_byte == 8'h00 && result.last_byte && !result.frame_end))
        else $error("malformed error result");

endmodule

bind modbus_rtu_request_framer mrf_checker u_mrf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire
